>>> src/gwlm_pkg.sv
// gwlm_pkg: shared constants, register indexes, mode codes, control structs
// and the sigmoid table generator for the grayscale window/level map.
// No dependencies.
package gwlm_pkg;

    localparam int SIGMOID_LUT_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF      = 17;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    // divisor width: window width shifted left by ten
    localparam int DVW        = 41;

    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOPE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTERCEPT = 3'd4;

    localparam logic [1:0] MODE_DYN   = 2'd0;
    localparam logic [1:0] MODE_LIN   = 2'd1;
    localparam logic [1:0] MODE_EXACT = 2'd2;
    localparam logic [1:0] MODE_SIG   = 2'd3;

    typedef struct packed {
        logic take;
        logic scan;
        logic mul;
        logic sub;
        logic setup;
        logic post;
        logic load_out;
    } gwlm_cmd_t;

    typedef struct packed {
        logic need_div;
        logic div_done;
        logic out_free;
    } gwlm_sts_t;

    // Restoring long division, used only while building the table.
    function automatic longint unsigned udiv(input longint unsigned n,
                                             input longint unsigned d);
        longint unsigned q;
        longint unsigned r;
        int              i;
        q = 0;
        r = 0;
        for (i = 63; i >= 0; i--)
        begin
            r = {r[62:0], n[i]};
            if (r >= d)
            begin
                r    = r - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Table entry: round(255 / (1 + e^-x)) at the bin midpoint, x in [-8, 8].
    // Evaluated at elaboration only.
    function automatic logic [7:0] sigmoid_entry(input int idx, input int lb);
        longint unsigned q1;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned v;
        longint unsigned m;
        longint unsigned z;
        longint unsigned den;
        longint unsigned num;
        longint unsigned g;
        longint          pos;
        int              k;
        q1  = 64'd1 << 30;
        pos = 2 * longint'(idx) + 1 - (longint'(1) << lb);
        m   = (pos < 0) ? longint'(-pos) : longint'(pos);
        v   = m << (30 - lb);
        sum  = q1;
        term = q1;
        for (k = 1; k <= 20; k++) begin
            term = udiv((term * v) >> 30, 64'(unsigned'(k)));
            sum  = sum + term;
        end
        z = udiv((q1 << 30) + (sum >> 1), sum);
        for (k = 0; k < 3; k++) begin
            z = (z * z + (q1 >> 1)) >> 30;
        end
        den = q1 + z;
        num = (pos > 0) ? 255 * q1 : 255 * z;
        g   = udiv(2 * num + den, 2 * den);
        return (g > 255) ? 8'd255 : g[7:0];
    endfunction

endpackage

>>> src/gwlm_div.sv
// gwlm_div: iterative restoring divider, one quotient bit per cycle,
// quotient saturated to all ones. Depends on gwlm_pkg.
module gwlm_div
    import gwlm_pkg::*;
#(
    parameter int NW = 62,
    parameter int KB = 10
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [NW-1:0]   num,
    input  logic [DVW-1:0]  den,
    output logic            done,
    output logic [KB-1:0]   quo
);

    localparam int CW   = ((NW > DVW + KB) ? NW : DVW + KB) + 1;
    localparam int CNTW = $clog2(KB + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0]   rem_reg, rem_next;
    logic [CW-1:0]   dsh_reg, dsh_next;
    logic [KB:0]     quo_reg, quo_next;
    logic            ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNTW'(KB);
            rem_next  = CW'(num);
            dsh_next  = CW'(den) << KB;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            quo_next = {quo_reg[KB-1:0], ge};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    // top bit set means quotient reached 2^KB: saturate
    assign quo  = quo_reg[KB] ? '1 : quo_reg[KB-1:0];

endmodule

>>> src/gwlm_dp.sv
// gwlm_dp: datapath - configuration registers, scan min/max, rescale
// multiplier, mode setup, shared divider, sigmoid table, output register.
// Depends on gwlm_pkg and gwlm_div.
module gwlm_dp
    import gwlm_pkg::*;
#(
    parameter int LB = SIGMOID_LUT_BITS_DEF,
    parameter int SB = SAMPLE_BITS_DEF
)(
    input  logic                   clk,
    input  logic                   rst_n,
    input  gwlm_cmd_t              cmd,
    output gwlm_sts_t              sts,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic signed [SB-1:0]   sample,
    input  logic                   frame_start,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic [7:0]             gray
);

    localparam int AW   = SB + 33;
    localparam int DW   = AW + 1;
    localparam int NW   = DW + LB + 1;
    localparam int KB   = (LB > 8) ? LB : 8;
    localparam int L    = 1 << LB;
    localparam int HALF = 1 << (LB - 1);

    localparam logic signed [SB-1:0] MIN_RST = SB'((1 << (SB - 1)) - 1);
    localparam logic signed [SB-1:0] MAX_RST = SB'(-(1 << (SB - 2)));

    // configuration
    logic [1:0]         mode_reg;
    logic signed [31:0] center_reg;
    logic [30:0]        width_reg;
    logic signed [31:0] slope_reg;
    logic signed [31:0] icpt_reg;

    // scan state
    logic signed [SB-1:0] min_reg, min_next;
    logic signed [SB-1:0] max_reg, max_next;
    logic [SB:0]          dyn_reg, dyn_next;

    // derived linear window
    logic [30:0]        ls_reg, ls_next;
    logic signed [40:0] lo_reg, lo_next;
    logic signed [40:0] c16;

    // item pipeline
    logic signed [SB-1:0]  s_reg;
    logic signed [AW-1:0]  a_reg, a_next;
    logic signed [31+SB:0] prod;
    logic signed [SB:0]    diff_reg;
    logic signed [DW-1:0]  d_reg, d_next;
    logic [KB-1:0]         q_reg, q_next;
    logic                  neg_reg, neg_next;
    logic [7:0]            res_reg, res_next;
    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            gray_reg;

    // setup
    logic                  need_div;
    logic [KB-1:0]         imm_q;
    logic                  imm_neg;
    logic [NW-1:0]         div_num;
    logic [DVW-1:0]        div_den;
    logic [38:0]           span;
    logic [DW-1:0]         mag;
    logic [NW-1:0]         nsig;
    logic                  div_done;
    logic [KB-1:0]         div_quo;

    // table
    logic [7:0]    rom_w [L];
    logic [LB-1:0] idx;

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_DYN;
            center_reg <= 32'sd32768;
            width_reg  <= 31'd65536;
            slope_reg  <= 32'sd65536;
            icpt_reg   <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MODE:      mode_reg   <= cfg_data[1:0];
                REG_CENTER:    center_reg <= $signed(cfg_data);
                REG_WIDTH:     width_reg  <= cfg_data[30:0];
                REG_SLOPE:     slope_reg  <= $signed(cfg_data);
                REG_INTERCEPT: icpt_reg   <= $signed(cfg_data);
                default:       mode_reg   <= mode_reg;
            endcase
        end
    end

    // ---------------- derived linear window ----------------
    always_comb
    begin
        c16 = 41'(center_reg) <<< 8;
        if (mode_reg == MODE_EXACT)
        begin
            ls_next = width_reg;
            lo_next = c16 - $signed(41'({width_reg, 7'b0}));
        end
        else if (width_reg > 31'd256)
        begin
            ls_next = width_reg - 31'd256;
            lo_next = c16 - 41'sd32768 - $signed(41'({ls_next, 7'b0}));
        end
        else
        begin
            ls_next = '0;
            lo_next = c16 - 41'sd32768;
        end
    end

    always_ff @(posedge clk)
    begin
        ls_reg <= ls_next;
        lo_reg <= lo_next;
    end

    // ---------------- scan ----------------
    always_comb
    begin
        min_next = min_reg;
        max_next = max_reg;
        dyn_next = dyn_reg;
        if (cmd.scan)
        begin
            if (frame_start)
            begin
                min_next = sample;
                max_next = sample;
            end
            else
            begin
                min_next = (sample < min_reg) ? sample : min_reg;
                max_next = (sample > max_reg) ? sample : max_reg;
            end
            dyn_next = (SB+1)'((SB+1)'(max_next) - (SB+1)'(min_next));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg <= MIN_RST;
            max_reg <= MAX_RST;
            dyn_reg <= '0;
        end
        else
        begin
            min_reg <= min_next;
            max_reg <= max_next;
            dyn_reg <= dyn_next;
        end
    end

    // ---------------- rescale and difference ----------------
    assign prod   = slope_reg * s_reg;
    assign a_next = AW'(prod) + (AW'(icpt_reg) <<< 8);
    assign d_next = (mode_reg == MODE_SIG) ? (DW'(a_reg) - (DW'(center_reg) <<< 8))
                                           : (DW'(a_reg) - DW'(lo_reg));

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            s_reg <= sample;
        end
        if (cmd.mul)
        begin
            a_reg    <= a_next;
            diff_reg <= (SB+1)'(s_reg) - (SB+1)'(min_reg);
        end
        if (cmd.sub)
        begin
            d_reg <= d_next;
        end
    end

    // ---------------- mode setup ----------------
    assign span = {ls_reg, 8'b0};
    assign mag  = (d_reg < 0) ? DW'(-d_reg) : DW'(d_reg);
    assign nsig = NW'(mag) << LB;

    always_comb
    begin
        need_div = 1'b0;
        imm_q    = '0;
        imm_neg  = 1'b0;
        div_num  = '0;
        div_den  = '0;
        case (mode_reg)
            MODE_DYN:
            begin
                if (slope_reg != 0 && dyn_reg != '0 && diff_reg > 0)
                begin
                    need_div = 1'b1;
                    div_num  = NW'(diff_reg[SB-1:0]) * NW'(510) + NW'(dyn_reg);
                    div_den  = DVW'(dyn_reg) << 1;
                end
            end
            MODE_SIG:
            begin
                imm_neg = (d_reg < 0);
                if (width_reg == '0)
                begin
                    imm_q = (d_reg != 0) ? '1 : '0;
                end
                else
                begin
                    need_div = 1'b1;
                    div_den  = DVW'(width_reg) << 10;
                    div_num  = imm_neg ? (nsig + NW'(div_den) - NW'(1)) : nsig;
                end
            end
            default:
            begin
                // linear and linear exact
                if (d_reg <= 0)
                begin
                    imm_q = '0;
                end
                else if (span == '0 || d_reg > $signed(DW'(span)))
                begin
                    imm_q = KB'(255);
                end
                else
                begin
                    need_div = 1'b1;
                    div_num  = NW'(d_reg) * NW'(510) + NW'(span);
                    div_den  = DVW'(span) << 1;
                end
            end
        endcase
    end

    gwlm_div #(
        .NW (NW),
        .KB (KB)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.setup & need_div),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        q_next   = q_reg;
        neg_next = neg_reg;
        if (cmd.setup)
        begin
            neg_next = imm_neg;
            if (!need_div)
            begin
                q_next = imm_q;
            end
        end
        else if (div_done)
        begin
            q_next = div_quo;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    // ---------------- table and final value ----------------
    for (genvar g = 0; g < L; g++)
    begin : g_rom
        localparam logic [7:0] ENT = sigmoid_entry(g, LB);
        assign rom_w[g] = ENT;
    end

    always_comb
    begin
        if (!neg_reg)
        begin
            idx = (q_reg >= KB'(HALF)) ? '1 : (LB'(HALF) + q_reg[LB-1:0]);
        end
        else
        begin
            idx = (q_reg > KB'(HALF)) ? '0 : (LB'(HALF) - q_reg[LB-1:0]);
        end
        if (mode_reg == MODE_SIG)
        begin
            res_next = rom_w[idx];
        end
        else
        begin
            res_next = (q_reg > KB'(255)) ? 8'd255 : q_reg[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.post)
        begin
            res_reg <= res_next;
        end
        if (cmd.load_out)
        begin
            gray_reg <= res_reg;
        end
    end

    // ---------------- output register ----------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    assign sts.need_div = need_div;
    assign sts.div_done = div_done;
    assign sts.out_free = !out_valid_reg || !out_stall;
    assign out_valid    = out_valid_reg;
    assign gray         = gray_reg;

endmodule

>>> src/gwlm_ctrl.sv
// gwlm_ctrl: sequencing state machine for one request at a time.
// Depends on gwlm_pkg.
module gwlm_ctrl
    import gwlm_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      op,
    output logic      in_stall,
    input  gwlm_sts_t sts,
    output gwlm_cmd_t cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SUB   = 3'd2;
    localparam logic [2:0] ST_SETUP = 3'd3;
    localparam logic [2:0] ST_DIV   = 3'd4;
    localparam logic [2:0] ST_POST  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;

    logic [2:0] state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (op)
                    begin
                        cmd.take   = 1'b1;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        cmd.scan = 1'b1;
                    end
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_SUB;
            end
            ST_SUB:
            begin
                cmd.sub    = 1'b1;
                state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = sts.need_div ? ST_DIV : ST_POST;
            end
            ST_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                cmd.post   = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> src/grayscale_window_level_map.sv
// grayscale_window_level_map: top level, maps raw samples to 8-bit gray.
// Depends on gwlm_pkg, gwlm_ctrl, gwlm_dp (and gwlm_div below it).
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------
//  in      | in_valid / in_stall  | op, sample, frame_start
//  out     | out_valid / out_stall| gray
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A scan request (op 0) gives no result.
// A map request (op 1) steps through multiply, subtract, setup, divide,
// post and output; the iterative divider, one quotient bit a cycle, gives a
// KB-bit quotient, KB = max(8, SIGMOID_LUT_BITS). Requests that need no division skip the divider.
// Reset is asynchronous and clears control, scan min/max and config registers.
// The finished gray value sits in an output register; a stall there holds
// only the final step, and the input is taken again once it moves.
module grayscale_window_level_map
    import gwlm_pkg::*;
#(
    parameter int SIGMOID_LUT_BITS = SIGMOID_LUT_BITS_DEF,
    parameter int SAMPLE_BITS      = SAMPLE_BITS_DEF
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic                          frame_start,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    gray,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    gwlm_cmd_t cmd;
    gwlm_sts_t sts;

    // the user must write registers only between requests; the block does not enforce it: always ready
    assign cfg_ready = 1'b1;

    gwlm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    gwlm_dp #(
        .LB (SIGMOID_LUT_BITS),
        .SB (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_we      (cfg_valid & cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .sample      (sample),
        .frame_start (frame_start),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .gray        (gray)
    );

endmodule

>>> dv/gwlm_checker.sv
// gwlm_checker: watches the request, result and register channels of the
// grayscale window/level map, predicts each gray value and compares it.
// Depends on gwlm_pkg.
`timescale 1ns / 100ps

module gwlm_checker
    import gwlm_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_stall,
    input  logic                  op,
    input  logic signed [16:0]    sample,
    input  logic                  frame_start,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  logic [7:0]            gray,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam longint LUT_N = 1024;

    logic [7:0] sig_rom [0:1023];
    logic [7:0] gray_queue [$];

    logic [1:0]    mode_r;
    longint        center_r;
    longint        width_r;
    longint        slope_r;
    longint        icept_r;
    longint        scan_lo;
    longint        scan_hi;
    logic          scan_seen;

    // Build the sigmoid table on its own: Q2.30 exp series, then the
    // reciprocal raised to the eighth power by three squarings.
    function automatic logic [7:0] sig_value(input longint idx);
        longint unsigned one, s, t, v, z, den, num, g;
        longint          pos;
        int              k;
        one = 64'd1 << 30;
        pos = 2 * idx + 1 - LUT_N;
        v = longint'(pos < 0 ? -pos : pos) << 20;
        s = one;
        t = one;
        for (k = 1; k <= 20; k++)
        begin
            t = ((t * v) >> 30) / k;
            s += t;
        end
        z = ((one << 30) + s / 2) / s;
        for (k = 0; k < 3; k++)
            z = (z * z + (one >> 1)) >> 30;
        den = one + z;
        num = pos > 0 ? 255 * one : 255 * z;
        g = (2 * num + den) / (2 * den);
        return g > 255 ? 8'd255 : g[7:0];
    endfunction

    function automatic logic [7:0] round_clip(input longint num, input longint den);
        longint q;
        if (den == 0)
            return 8'd0;
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return 8'd0;
        q = (num * 2 + den) / (den * 2);
        return q > 255 ? 8'd255 : q[7:0];
    endfunction

    function automatic logic [7:0] map_gray(input longint s);
        longint a, d, q, idx, span, lo;
        a = slope_r * s + icept_r * 256;
        case (mode_r)
            MODE_DYN:
                // range stays zero until the first scan
                return slope_r == 0 ? 8'd0
                                    : round_clip(255 * (s - scan_lo),
                                                 scan_seen ? scan_hi - scan_lo : 0);
            MODE_SIG:
            begin
                d = a - center_r * 256;
                if (width_r == 0)
                    idx = d > 0 ? LUT_N - 1 : (d < 0 ? 0 : LUT_N / 2);
                else
                begin
                    q = d * LUT_N;
                    // floor division toward minus infinity
                    q = q >= 0 ? q / (width_r * 1024)
                               : -((-q + width_r * 1024 - 1) / (width_r * 1024));
                    idx = q < -LUT_N / 2 ? 0 : (q >= LUT_N / 2 ? LUT_N - 1 : q + LUT_N / 2);
                end
                return sig_rom[idx];
            end
            default:
            begin
                if (mode_r == MODE_EXACT)
                begin
                    span = width_r;
                    lo = center_r * 256 - width_r * 128;
                end
                else if (width_r > 256)
                begin
                    span = width_r - 256;
                    lo = center_r * 256 - 32768 - span * 128;
                end
                else
                begin
                    span = 0;
                    lo = center_r * 256 - 32768;
                end
                span = span * 256;
                d = a - lo;
                if (d <= 0)
                    return 8'd0;
                if (span == 0 || d > span)
                    return 8'd255;
                return round_clip(255 * d, span);
            end
        endcase
    endfunction

    initial
        for (int i = 0; i < LUT_N; i++)
            sig_rom[i] = sig_value(i);

    assign pending = gray_queue.size();

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            errors    <= 0;
            mode_r    <= MODE_DYN;
            center_r  <= 32768;
            width_r   <= 65536;
            slope_r   <= 65536;
            icept_r   <= 0;
            scan_lo   <= 65535;
            scan_hi   <= -32768;
            scan_seen <= 1'b0;
            gray_queue.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                case (cfg_index)
                    REG_MODE:      mode_r   <= cfg_data[1:0];
                    REG_CENTER:    center_r <= longint'(signed'(cfg_data));
                    REG_WIDTH:     width_r  <= longint'(cfg_data[30:0]);
                    REG_SLOPE:     slope_r  <= longint'(signed'(cfg_data));
                    REG_INTERCEPT: icept_r  <= longint'(signed'(cfg_data));
                    default: ;
                endcase
            if (in_valid && !in_stall)
            begin
                if (!op)
                begin
                    scan_seen <= 1'b1;
                    if (frame_start)
                    begin
                        scan_lo <= sample;
                        scan_hi <= sample;
                    end
                    else
                    begin
                        if (sample < scan_lo) scan_lo <= sample;
                        if (sample > scan_hi) scan_hi <= sample;
                    end
                end
                else
                    gray_queue.push_back(map_gray(sample));
            end
            if (out_valid && !out_stall)
            begin
                if (gray_queue.size() == 0)
                begin
                    $display("%0t: unexpected gray, expected none, actual %0d", $time, gray);
                    errors <= errors + 1;
                end
                else if (gray_queue[0] !== gray)
                begin
                    $display("%0t: gray mismatch, expected %0d, actual %0d",
                             $time, gray_queue[0], gray);
                    errors <= errors + 1;
                    void'(gray_queue.pop_front());
                end
                else
                    void'(gray_queue.pop_front());
            end
        end
    end

endmodule

>>> dv/grayscale_window_level_map_tb.sv
// grayscale_window_level_map_tb: drives requests, register writes and output
// stalls into the window/level map; gwlm_checker predicts and compares.
// Depends on gwlm_pkg, gwlm_checker and the block itself.
`timescale 1ns / 100ps

module grayscale_window_level_map_tb;
    import gwlm_pkg::*;

    localparam int LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  op;
    logic signed [16:0]    sample;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [7:0]            gray;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    quiet_cycles = 0;
    int                    stall_mode = 0;

    grayscale_window_level_map dut (.*);

    gwlm_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog: count cycles with no traffic on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Output stall pattern: phases of none, light, heavy stalling.
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    // One write held until ready, then valid drops before the next write may start.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold one request until it is taken; raise valid only here.
    task automatic send_request(input logic o, input logic signed [16:0] s, input logic f);
        in_valid    <= 1'b1;
        op          <= o;
        sample      <= s;
        frame_start <= f;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid for a random gap, sometimes none, so bursts form.
    task automatic maybe_gap();
        int n;
        if ($urandom_range(0, 2) != 0)
            return;
        in_valid <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(posedge clk);
    endtask

    // Wait for all results, then hold idle before writing.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic signed [16:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return -17'sd32768;
            1: return 17'sd65535;
            2: return $signed(17'($urandom_range(0, 4095)));
            default: return 17'($urandom_range(0, 98303)) - 17'sd32768;
        endcase
    endfunction

    function automatic logic [31:0] rand_reg(input int idx);
        case (idx)
            REG_MODE:   return $urandom_range(0, 3);
            REG_CENTER:
                case ($urandom_range(0, 3))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    default: return 32'($signed($urandom_range(0, 40000)) - 10000) <<< 8;
                endcase
            REG_WIDTH:
                case ($urandom_range(0, 5))
                    0: return 32'd0;
                    1: return $urandom_range(1, 256);
                    2: return 32'h7FFF_FFFF;
                    3: return $urandom;
                    default: return $urandom_range(257, 20000 * 256);
                endcase
            REG_SLOPE:
                case ($urandom_range(0, 5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'd0;
                    3: return $urandom;
                    default: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
                endcase
            default:
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return $urandom;
                    default: return 32'($signed($urandom_range(0, 4000)) - 2000) <<< 8;
                endcase
        endcase
    endfunction

    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = 1'b0;
        sample      = '0;
        frame_start = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: whole dynamics with no scan yet, then a scan pass.
        send_request(1'b1, 17'sd100, 1'b0);
        send_request(1'b0, 17'sd1000, 1'b1);
        send_request(1'b1, 17'sd1000, 1'b0);          // zero scan range
        send_request(1'b0, -17'sd32768, 1'b0);
        send_request(1'b0, 17'sd65535, 1'b0);
        send_request(1'b1, -17'sd32768, 1'b0);
        send_request(1'b1, 17'sd65535, 1'b0);
        send_request(1'b1, 17'sd0, 1'b0);
        send_request(1'b0, 17'sd10, 1'b1);
        send_request(1'b0, 17'sd20, 1'b0);
        send_request(1'b1, 17'sd5, 1'b0);             // below scanned range
        send_request(1'b1, 17'sd30, 1'b0);            // above scanned range
        send_request(1'b1, 17'sd15, 1'b0);
        drain();

        // Directed: narrow, zero width and the other modes.
        write_reg(REG_WIDTH, 32'd256);
        write_reg(REG_MODE, 32'(MODE_LIN));
        drain();
        send_request(1'b1, 17'sd127, 1'b0);
        send_request(1'b1, 17'sd128, 1'b0);
        drain();
        write_reg(REG_WIDTH, 32'd0);
        write_reg(REG_MODE, 32'(MODE_EXACT));
        drain();
        send_request(1'b1, 17'sd128, 1'b0);
        send_request(1'b1, 17'sd129, 1'b0);
        drain();
        write_reg(REG_MODE, 32'(MODE_SIG));
        drain();
        send_request(1'b1, 17'sd127, 1'b0);
        send_request(1'b1, 17'sd128, 1'b0);
        send_request(1'b1, 17'sd129, 1'b0);
        drain();
        write_reg(3'd7, 32'hFFFF_FFFF);               // unused index
        drain();

        // Random phases: new settings, then scans and maps mixed at random with random content.
        for (int ph = 0; ph < 30; ph++)
        begin
            drain();
            for (int r = 0; r < 5; r++)
                if (ph < 5 || $urandom_range(0, 1))
                    write_reg(CFG_IDX_W'(r), rand_reg(r));
            drain();
            for (int k = 0; k < 20; k++)
            begin
                if ($urandom_range(0, 3) == 0)
                    send_request(1'b0, rand_sample(), $urandom_range(0, 7) == 0);
                else
                    send_request(1'b1, rand_sample(), 1'($urandom));
                maybe_gap();
            end
        end
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> filelist.f
src/gwlm_pkg.sv
src/gwlm_div.sv
src/gwlm_dp.sv
src/gwlm_ctrl.sv
src/grayscale_window_level_map.sv
dv/gwlm_checker.sv
dv/grayscale_window_level_map_tb.sv
